// ===== rtl/kli_pkg.sv =====
// Shared types and constants for the keyframe linear interpolator.
`default_nettype none
package kli_pkg;
   localparam int MaxKeyframesDefault = 16;
   localparam int TimeWidth  = 32;
   localparam int ValueWidth = 32;
   localparam int StatusWidth = 2;
   localparam int TotalWidth = 5;

   localparam logic CMD_INSERT   = 1'b0;
   localparam logic CMD_EVALUATE = 1'b1;

   localparam logic [StatusWidth-1:0] STATUS_OK    = 2'd0;
   localparam logic [StatusWidth-1:0] STATUS_FULL  = 2'd1;
   localparam logic [StatusWidth-1:0] STATUS_EMPTY = 2'd2;

   // commands from controller to datapath
   typedef struct packed {
      logic load;        // capture request, reset scan index
      logic ins_step;    // move entry idx-1 to idx, decrement idx
      logic ins_write;   // write new pair at idx, bump count
      logic ev_step;     // keep read as left neighbor, advance search index
      logic ev_grab;     // latch bracketing pair, compute divisor
      logic mul_step;    // one multiply partial step
      logic div_start;   // prepare divider
      logic div_step;    // one restoring division step
      logic rd_issue;    // issue memory read at scan index
      logic rd_last;     // issue memory read at the last held entry
      logic finish;      // load output register
      logic [StatusWidth-1:0] fin_status;
      logic fin_zero;    // output zero result
      logic fin_direct;  // output latched value directly
   } kli_cmd_type;

   typedef struct packed {
      logic is_eval;
      logic full;
      logic empty;
      logic idx_zero;     // index reached zero
      logic prev_gt;      // entry idx-1 time greater than new time
      logic ge_last;      // query at or after the time just read
      logic scan_hit;     // query at or before the time just read
      logic mul_done;
      logic div_done;
      logic out_busy;     // output register holds untaken result
   } kli_sts_type;
endpackage
`default_nettype wire

// ===== rtl/kli_if.sv =====
// Valid/ready channel interfaces for the interpolator.
`default_nettype none
interface kli_req_if;
   import kli_pkg::*;
   logic valid;
   logic ready;
   logic cmd;
   logic [TimeWidth-1:0] time_point;
   logic signed [ValueWidth-1:0] key_value;
   modport source (output valid, cmd, time_point, key_value, input ready);
   modport sink (input valid, cmd, time_point, key_value, output ready);
endinterface

interface kli_rsp_if;
   import kli_pkg::*;
   logic valid;
   logic ready;
   logic signed [ValueWidth-1:0] result_value;
   logic [StatusWidth-1:0] status;
   logic [TotalWidth-1:0] entry_total;
   modport source (output valid, result_value, status, entry_total, input ready);
   modport sink (input valid, result_value, status, entry_total, output ready);
endinterface
`default_nettype wire

// ===== rtl/kli_datapath.sv =====
// Keyframe storage, search, multiply and divide datapath.
`default_nettype none
module kli_datapath import kli_pkg::*; #(
   parameter int MAX_KEYFRAMES = MaxKeyframesDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire kli_cmd_type cmd_i,
   output kli_sts_type sts_o,
   input  wire logic req_cmd,
   input  wire logic [TimeWidth-1:0] req_time_point,
   input  wire logic [ValueWidth-1:0] req_key_value,
   output logic [ValueWidth-1:0] rsp_result_value,
   output logic [StatusWidth-1:0] rsp_status,
   output logic [TotalWidth-1:0] rsp_entry_total,
   output logic rsp_valid,
   input  wire logic rsp_ready
);
   localparam int IdxW = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;
   localparam int CntW = $clog2(MAX_KEYFRAMES + 1);
   localparam int ProdW = 65;

   logic [TimeWidth-1:0]  times_mem  [MAX_KEYFRAMES];
   logic [ValueWidth-1:0] values_mem [MAX_KEYFRAMES];

   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] idx_ff;
   logic cmd_ff;
   logic [TimeWidth-1:0] t_ff;
   logic [ValueWidth-1:0] v_ff;
   logic [TimeWidth-1:0] rd_t_ff, prev_t_ff;
   logic [ValueWidth-1:0] rd_v_ff, prev_v_ff;
   logic neg_ff;
   logic [32:0] mag_ff;
   logic [TimeWidth-1:0] n_ff;
   logic [TimeWidth-1:0] den_ff;
   logic [ProdW-1:0] prod_ff;
   logic [5:0] mcnt_ff;
   logic [6:0] dcnt_ff;
   logic [32:0] rem_ff;
   logic [ProdW-1:0] quo_ff;
   logic [ValueWidth-1:0] out_val_ff;
   logic [StatusWidth-1:0] out_sts_ff;
   logic [TotalWidth-1:0] out_tot_ff;
   logic out_vld_ff;

   logic [CntW-1:0] rd_sel;
   logic [IdxW-1:0] rd_addr;
   logic [IdxW-1:0] idx_lo;
   logic signed [32:0] diff;
   logic [33:0] rem_sh;
   logic [33:0] rem_sub;
   logic [ValueWidth-1:0] interp;

   // read address: last entry, hole-1 while inserting, scan index while evaluating
   always_comb begin
      if (cmd_i.rd_last) begin
         rd_sel = count_ff - CntW'(1);
      end else if (cmd_ff == CMD_INSERT) begin
         rd_sel = idx_ff - CntW'(1);
      end else begin
         rd_sel = idx_ff;
      end
   end

   assign idx_lo = idx_ff[IdxW-1:0];
   assign rd_addr = rd_sel[IdxW-1:0];

   // memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (cmd_i.ins_step) begin
         times_mem[idx_lo]  <= rd_t_ff;
         values_mem[idx_lo] <= rd_v_ff;
      end else if (cmd_i.ins_write) begin
         times_mem[idx_lo]  <= t_ff;
         values_mem[idx_lo] <= v_ff;
      end
      if (cmd_i.rd_issue || cmd_i.rd_last) begin
         rd_t_ff <= times_mem[rd_addr];
         rd_v_ff <= values_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd_i.ins_write) begin
         count_ff <= count_ff + CntW'(1);
      end
   end

   // index: insert walks down from count, evaluate walks up from 0
   always_ff @(posedge clock) begin
      if (cmd_i.load) begin
         cmd_ff <= req_cmd;
         t_ff <= req_time_point;
         v_ff <= req_key_value;
         idx_ff <= (req_cmd == CMD_INSERT) ? count_ff : '0;
      end else if (cmd_i.ins_step) begin
         idx_ff <= idx_ff - CntW'(1);
      end else if (cmd_i.ev_step) begin
         idx_ff <= idx_ff + CntW'(1);
      end
   end

   // left neighbor: keep the previous read while scanning
   always_ff @(posedge clock) begin
      if (cmd_i.ev_step) begin
         prev_t_ff <= rd_t_ff;
         prev_v_ff <= rd_v_ff;
      end
   end

   assign diff = $signed({rd_v_ff[31], rd_v_ff}) - $signed({prev_v_ff[31], prev_v_ff});

   always_ff @(posedge clock) begin
      if (cmd_i.ev_grab) begin
         neg_ff <= diff[32];
         mag_ff <= diff[32] ? 33'(-diff) : 33'(diff);
         n_ff <= t_ff - prev_t_ff;
         den_ff <= rd_t_ff - prev_t_ff;
         prod_ff <= '0;
         mcnt_ff <= '0;
      end else if (cmd_i.mul_step) begin
         // shift-add, one multiplier bit per cycle, MSB first
         prod_ff <= {prod_ff[ProdW-2:0], 1'b0}
                  + (n_ff[TimeWidth-1] ? ProdW'(mag_ff) : '0);
         n_ff <= {n_ff[TimeWidth-2:0], 1'b0};
         mcnt_ff <= mcnt_ff + 6'd1;
      end
   end

   assign rem_sh  = {rem_ff, quo_ff[ProdW-1]};
   assign rem_sub = rem_sh - {2'b00, den_ff};

   always_ff @(posedge clock) begin
      if (cmd_i.div_start) begin
         rem_ff <= '0;
         quo_ff <= prod_ff;
         dcnt_ff <= '0;
      end else if (cmd_i.div_step) begin
         if (!rem_sub[33]) begin
            rem_ff <= rem_sub[32:0];
            quo_ff <= {quo_ff[ProdW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[32:0];
            quo_ff <= {quo_ff[ProdW-2:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff + 7'd1;
      end
   end

   assign interp = neg_ff ? (prev_v_ff - quo_ff[ValueWidth-1:0])
                          : (prev_v_ff + quo_ff[ValueWidth-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (cmd_i.finish) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.finish) begin
         out_sts_ff <= cmd_i.fin_status;
         out_tot_ff <= TotalWidth'(count_ff);
         if (cmd_i.fin_zero) begin
            out_val_ff <= '0;
         end else if (cmd_i.fin_direct) begin
            out_val_ff <= rd_v_ff;
         end else begin
            out_val_ff <= interp;
         end
      end
   end

   assign rsp_result_value = out_val_ff;
   assign rsp_status = out_sts_ff;
   assign rsp_entry_total = out_tot_ff;
   assign rsp_valid = out_vld_ff;

   always_comb begin
      sts_o = '0;
      sts_o.is_eval  = cmd_ff;
      sts_o.full     = (count_ff == CntW'(MAX_KEYFRAMES));
      sts_o.empty    = (count_ff == '0);
      sts_o.idx_zero = (idx_ff == '0);
      sts_o.prev_gt  = (rd_t_ff > t_ff);
      sts_o.ge_last  = (t_ff >= rd_t_ff);
      sts_o.scan_hit = (t_ff <= rd_t_ff);
      sts_o.mul_done = (mcnt_ff == 6'd32);
      sts_o.div_done = (dcnt_ff == 7'(ProdW));
      sts_o.out_busy = out_vld_ff && !rsp_ready;
   end
endmodule
`default_nettype wire

// ===== rtl/kli_control.sv =====
// Sequencing state machine for insert and evaluate requests.
`default_nettype none
module kli_control import kli_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire kli_sts_type sts_i,
   output kli_cmd_type cmd_o
);
   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_DECIDE = 9'b000000010,
      S_IWALK  = 9'b000000100,
      S_ELAST  = 9'b000001000,
      S_ECHK   = 9'b000010000,
      S_ERD    = 9'b000100000,
      S_MUL    = 9'b001000000,
      S_DIV    = 9'b010000000,
      S_FIN    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [StatusWidth-1:0] st_ff, st_in;
   logic zero_ff, zero_in, dir_ff, dir_in;
   logic walk_start, walk_rd, walk_step, walk_write, walk_done;

   kli_insert_walk u_walk (
      .clock(clock), .reset(reset), .start(walk_start),
      .idx_zero(sts_i.idx_zero), .prev_gt(sts_i.prev_gt),
      .rd_issue(walk_rd), .ins_step(walk_step), .ins_write(walk_write),
      .done(walk_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         st_ff <= STATUS_OK;
         zero_ff <= 1'b0;
         dir_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         st_ff <= st_in;
         zero_ff <= zero_in;
         dir_ff <= dir_in;
      end
   end

   // evaluate checks the last entry first, then scans index 0 upward;
   // ev_step keeps the current read as the left neighbor before advancing
   always_comb begin
      state_in = state_ff;
      st_in = st_ff;
      zero_in = zero_ff;
      dir_in = dir_ff;
      walk_start = 1'b0;
      cmd_o = '0;
      cmd_o.rd_issue = walk_rd;
      cmd_o.ins_step = walk_step;
      cmd_o.ins_write = walk_write;
      cmd_o.fin_status = st_ff;
      cmd_o.fin_zero = zero_ff;
      cmd_o.fin_direct = dir_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_o.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            st_in = STATUS_OK;
            zero_in = 1'b0;
            dir_in = 1'b0;
            if (!sts_i.is_eval) begin
               zero_in = 1'b1;
               if (sts_i.full) begin
                  st_in = STATUS_FULL;
                  state_in = S_FIN;
               end else begin
                  walk_start = 1'b1;
                  state_in = S_IWALK;
               end
            end else if (sts_i.empty) begin
               st_in = STATUS_EMPTY;
               zero_in = 1'b1;
               state_in = S_FIN;
            end else begin
               cmd_o.rd_last = 1'b1;
               state_in = S_ELAST;
            end
         end
         S_IWALK: begin
            if (walk_done) begin
               state_in = S_FIN;
            end
         end
         S_ELAST: begin
            if (sts_i.ge_last) begin
               dir_in = 1'b1;
               state_in = S_FIN;
            end else begin
               cmd_o.rd_issue = 1'b1;
               state_in = S_ECHK;
            end
         end
         S_ECHK: begin
            if (sts_i.scan_hit) begin
               if (sts_i.idx_zero) begin
                  dir_in = 1'b1;
                  state_in = S_FIN;
               end else begin
                  cmd_o.ev_grab = 1'b1;
                  state_in = S_MUL;
               end
            end else begin
               cmd_o.ev_step = 1'b1;
               state_in = S_ERD;
            end
         end
         S_ERD: begin
            cmd_o.rd_issue = 1'b1;
            state_in = S_ECHK;
         end
         S_MUL: begin
            if (sts_i.mul_done) begin
               cmd_o.div_start = 1'b1;
               state_in = S_DIV;
            end else begin
               cmd_o.mul_step = 1'b1;
            end
         end
         S_DIV: begin
            if (sts_i.div_done) begin
               state_in = S_FIN;
            end else begin
               cmd_o.div_step = 1'b1;
            end
         end
         S_FIN: begin
            if (!sts_i.out_busy) begin
               cmd_o.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/kli_insert_walk.sv =====
// Insertion walk: shifts larger entries up one slot, each through the read, check and write states.
`default_nettype none
module kli_insert_walk import kli_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic idx_zero,
   input  wire logic prev_gt,
   output logic rd_issue,
   output logic ins_step,
   output logic ins_write,
   output logic done
);
   typedef enum logic [3:0] {
      W_IDLE = 4'b0001,
      W_RD   = 4'b0010,
      W_CHK  = 4'b0100,
      W_WR   = 4'b1000
   } walk_type;
   walk_type walk_ff, walk_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff <= W_IDLE;
      end else begin
         walk_ff <= walk_in;
      end
   end

   always_comb begin
      walk_in = walk_ff;
      rd_issue = 1'b0;
      ins_step = 1'b0;
      ins_write = 1'b0;
      done = 1'b0;
      unique case (walk_ff)
         W_IDLE: if (start) walk_in = idx_zero ? W_WR : W_RD;
         W_RD: begin
            rd_issue = 1'b1;
            walk_in = W_CHK;
         end
         W_CHK: begin
            if (prev_gt) begin
               ins_step = 1'b1;
               walk_in = W_WR;
            end else begin
               ins_write = 1'b1;
               done = 1'b1;
               walk_in = W_IDLE;
            end
         end
         W_WR: begin
            if (idx_zero) begin
               ins_write = 1'b1;
               done = 1'b1;
               walk_in = W_IDLE;
            end else begin
               walk_in = W_RD;
            end
         end
         default: walk_in = W_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/keyframe_linear_interpolator_unit.sv =====
// Top level of the keyframe linear interpolator.
//
// Usage: requests arrive on req_ (cmd, time_point, key_value); each gives
// exactly one response on rsp_ (result_value, status, entry_total).
// cmd insert places the pair in time order after equal times; a full table
// drops it with status full. cmd evaluate clamps outside the table span and
// otherwise interpolates linearly, truncating toward zero; an empty table
// gives zero with status empty.
// An insert into a full table goes straight to its response; otherwise it
// walks down from the top entry, shifting each entry with a later time up
// one slot. An evaluate checks the last entry first, then scans from index
// 0 upward; an interpolation then runs the serial shift-add multiplier and
// the restoring divider, which dominate its duration.
// One request is in work at a time; the controller returns to idle and
// accepts the next once the response register loads.
// Reset clears the keyframe count and all control; table contents are
// never read before being written.
// A stalled receiver holds the response register; the block finishes the
// next request internally and holds its response until the register is taken.
`default_nettype none
module keyframe_linear_interpolator_unit import kli_pkg::*; #(
   parameter int MAX_KEYFRAMES = MaxKeyframesDefault
) (
   input wire logic clock,
   input wire logic reset,
   kli_req_if.sink req,
   kli_rsp_if.source rsp
);
   kli_cmd_type cmd;
   kli_sts_type sts;

   kli_control u_ctl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .sts_i(sts), .cmd_o(cmd)
   );

   kli_datapath #(.MAX_KEYFRAMES(MAX_KEYFRAMES)) u_dp (
      .clock(clock), .reset(reset), .cmd_i(cmd), .sts_o(sts),
      .req_cmd(req.cmd), .req_time_point(req.time_point),
      .req_key_value(req.key_value),
      .rsp_result_value(rsp.result_value), .rsp_status(rsp.status),
      .rsp_entry_total(rsp.entry_total), .rsp_valid(rsp.valid),
      .rsp_ready(rsp.ready)
   );
endmodule
`default_nettype wire
